### rtl/darule_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// darule_pkg: shared types and constants of the daily alarm rule evaluator
// Holds the rule kind codes, the stage payload structs and the fixed time
// constants used by every pipeline stage.
// ----------------------------------------------------------------------------
package darule_pkg;

   localparam logic [16:0] DAY_SECONDS    = 17'd86400;
   localparam logic [10:0] DAY_MINUTES    = 11'd1440;
   localparam logic [5:0]  MINUTE_SECONDS = 6'd60;
   localparam logic [16:0] OFFSET_LIMIT   = 17'd50400;

   // Division by 86400 is a shift by 7 followed by a multiply with the
   // rounded-up reciprocal of 675 scaled by 2**36. It is exact for all
   // 26-bit quotient inputs.
   localparam int          DIV_PRESHIFT = 7;
   localparam int          RECIP_SHIFT  = 36;
   localparam logic [26:0] RECIP_MULT   = 27'd101806633;

   typedef enum logic [1:0] {
      FUNC_DISABLED = 2'd0,
      FUNC_ONESHOT  = 2'd1,
      FUNC_DAILY    = 2'd2,
      FUNC_UNUSED   = 2'd3
   } func_type;

   // What the front stage has decided about the rule.
   typedef enum logic [1:0] {
      MODE_NEVER = 2'd0,
      MODE_WAIT  = 2'd1,
      MODE_FIRE  = 2'd2,
      MODE_DAILY = 2'd3
   } mode_type;

   typedef struct packed {
      func_type           func;
      logic [31:0]        utc_seconds;
      logic [31:0]        due_mark;
      logic [10:0]        minute_of_day;
      logic signed [16:0] offset_seconds;
      logic [31:0]        last_mark;
      logic               queue_accepts;
   } req_type;

   typedef struct packed {
      mode_type           mode;
      logic [31:0]        utc;
      logic [31:0]        due;
      logic [31:0]        last;
      logic               accepts;
      logic signed [18:0] shift;
      logic signed [19:0] shift_minute;
      logic signed [19:0] shift_day;
      logic [49:0]        last_next_base;
   } common_type;

   typedef struct packed {
      common_type  com;
      logic [25:0] quot;
   } s1_type;

   typedef struct packed {
      common_type  com;
      logic [51:0] prod;
   } s2_type;

   typedef struct packed {
      common_type  com;
      logic [15:0] day;
      logic [32:0] day_base;
      logic        fired;
   } s3_type;

   typedef struct packed {
      logic        never;
      logic [48:0] next_deadline;
      logic        post_attempt;
      logic        posted;
      logic        blocked;
      logic [31:0] new_last_mark;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/darule_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// darule_front: rule decode stage
// Checks the rule settings, decides the one-shot outcome, forms local time
// and the daily target shift, and registers them.
// ----------------------------------------------------------------------------
module darule_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  darule_pkg::req_type  in_data,
   output logic                 out_valid,
   input  wire                  out_ready,
   output darule_pkg::s1_type   out_data
);
   import darule_pkg::*;

   logic               valid_ff;
   s1_type             data_ff;
   s1_type             data_in;
   logic signed [33:0] local_sum;
   logic [16:0]        minute_secs;
   logic               minute_ok;
   logic               offset_ok;

   always_comb begin
      local_sum   = $signed({2'b00, in_data.utc_seconds})
                  + $signed({{17{in_data.offset_seconds[16]}}, in_data.offset_seconds});
      minute_secs = {6'b0, in_data.minute_of_day} * {11'b0, MINUTE_SECONDS};
      minute_ok   = in_data.minute_of_day < DAY_MINUTES;
      offset_ok   = (in_data.offset_seconds >= -$signed(OFFSET_LIMIT))
                 && (in_data.offset_seconds <= $signed(OFFSET_LIMIT));

      data_in.quot         = local_sum[32:DIV_PRESHIFT];
      data_in.com.utc      = in_data.utc_seconds;
      data_in.com.due      = in_data.due_mark;
      data_in.com.last     = in_data.last_mark;
      data_in.com.accepts  = in_data.queue_accepts;
      data_in.com.shift    = $signed({2'b00, minute_secs})
                           - $signed({{2{in_data.offset_seconds[16]}}, in_data.offset_seconds});
      data_in.com.shift_minute = $signed({data_in.com.shift[18], data_in.com.shift})
                               + $signed({14'b0, MINUTE_SECONDS});
      data_in.com.shift_day    = $signed({data_in.com.shift[18], data_in.com.shift})
                               + $signed({3'b0, DAY_SECONDS});
      data_in.com.last_next_base = {17'b0, ({1'b0, in_data.last_mark} + 33'd1)}
                                 * {33'b0, DAY_SECONDS};

      data_in.com.mode = MODE_NEVER;
      if (in_data.utc_seconds != 32'd0 && in_data.func == FUNC_ONESHOT) begin
         if (in_data.due_mark != 32'd0 && in_data.last_mark != in_data.due_mark) begin
            if (in_data.utc_seconds < in_data.due_mark) begin
               data_in.com.mode = MODE_WAIT;
            end else begin
               data_in.com.mode = MODE_FIRE;
            end
         end
      end else if (in_data.utc_seconds != 32'd0 && in_data.func == FUNC_DAILY
                   && minute_ok && offset_ok && !local_sum[33]) begin
         data_in.com.mode = MODE_DAILY;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

### rtl/darule_divide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// darule_divide: local day number stages
// Two register stages: a reciprocal multiply that divides local time by one
// day, then the day start in seconds and the already-fired compare.
// ----------------------------------------------------------------------------
module darule_divide (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  darule_pkg::s1_type   in_data,
   output logic                 out_valid,
   input  wire                  out_ready,
   output darule_pkg::s3_type   out_data
);
   import darule_pkg::*;

   logic   s2_valid_ff;
   s2_type s2_ff;
   s2_type s2_in;
   logic   s2_ready;
   logic   s3_valid_ff;
   s3_type s3_ff;
   s3_type s3_in;
   logic   s3_ready;

   always_comb begin
      s2_in.com  = in_data.com;
      s2_in.prod = 52'({27'b0, in_data.quot} * {26'b0, RECIP_MULT});

      s3_in.com      = s2_ff.com;
      s3_in.day      = s2_ff.prod[RECIP_SHIFT+15:RECIP_SHIFT];
      s3_in.day_base = {17'b0, s3_in.day} * {16'b0, DAY_SECONDS};
      s3_in.fired    = s2_ff.com.last >= {16'b0, s3_in.day};
   end

   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign in_ready  = s2_ready;
   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= in_valid;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && in_valid) begin
         s2_ff <= s2_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

endmodule
`default_nettype wire

### rtl/darule_resolve.sv
`default_nettype none
// ----------------------------------------------------------------------------
// darule_resolve: deadline and post decision stage
// Forms the daily target seconds, picks the next deadline and the post
// outcome, and holds the result in the output register.
// ----------------------------------------------------------------------------
module darule_resolve (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  darule_pkg::s3_type   in_data,
   output logic                 out_valid,
   input  wire                  out_ready,
   output darule_pkg::rsp_type  out_data
);
   import darule_pkg::*;

   logic               valid_ff;
   rsp_type            data_ff;
   rsp_type            data_in;
   logic signed [35:0] now_secs;
   logic signed [35:0] target;
   logic signed [35:0] target_minute;
   logic signed [35:0] target_day;
   logic signed [50:0] fired_next;
   logic               early;
   logic               late;

   always_comb begin
      now_secs      = $signed({4'b0, in_data.com.utc});
      target        = $signed({3'b0, in_data.day_base})
                    + $signed({{17{in_data.com.shift[18]}}, in_data.com.shift});
      target_minute = $signed({3'b0, in_data.day_base})
                    + $signed({{16{in_data.com.shift_minute[19]}}, in_data.com.shift_minute});
      target_day    = $signed({3'b0, in_data.day_base})
                    + $signed({{16{in_data.com.shift_day[19]}}, in_data.com.shift_day});
      fired_next    = $signed({1'b0, in_data.com.last_next_base})
                    + $signed({{32{in_data.com.shift[18]}}, in_data.com.shift});
      early         = now_secs < target;
      late          = now_secs >= target_minute;

      data_in.never         = 1'b1;
      data_in.next_deadline = 49'd0;
      data_in.post_attempt  = 1'b0;
      data_in.posted        = 1'b0;
      data_in.blocked       = 1'b0;
      data_in.new_last_mark = in_data.com.last;

      case (in_data.com.mode)
         MODE_NEVER: begin
            data_in.never = 1'b1;
         end
         MODE_WAIT: begin
            data_in.never         = 1'b0;
            data_in.next_deadline = {17'b0, in_data.com.due};
         end
         MODE_FIRE: begin
            data_in.post_attempt = 1'b1;
            data_in.posted       = in_data.com.accepts;
            data_in.blocked      = !in_data.com.accepts;
            if (in_data.com.accepts) begin
               data_in.new_last_mark = in_data.com.due;
            end
         end
         MODE_DAILY: begin
            data_in.never = 1'b0;
            if (in_data.fired) begin
               data_in.next_deadline = fired_next[48:0];
            end else if (early) begin
               data_in.next_deadline = target[35:0] == 36'd0 ? 49'd0 : {13'b0, target};
            end else if (late) begin
               data_in.next_deadline = {13'b0, target_day};
            end else begin
               data_in.post_attempt = 1'b1;
               if (in_data.com.accepts) begin
                  data_in.posted        = 1'b1;
                  data_in.new_last_mark = {16'b0, in_data.day};
                  data_in.next_deadline = {13'b0, target_day};
               end else begin
                  data_in.blocked       = 1'b1;
                  data_in.next_deadline = {13'b0, target_minute};
               end
            end
         end
         default: begin
            data_in.never = 1'b1;
         end
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

### rtl/daily_alarm_rule_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// daily_alarm_rule_evaluator: alarm rule evaluation pipeline
// Evaluates one alarm rule per transfer against a UTC epoch second and
// returns the next deadline, the post outcome and the updated fired mark.
// ----------------------------------------------------------------------------
// Usage:
// A rule arrives as one transfer on the req_ channel: the rule kind on
// req_tuser and the time, marks, minute, offset and queue state on
// req_tdata. Every request transfer yields exactly one transfer on the
// rsp_ channel, in request order.
// The work runs through four register stages: rule decode, the reciprocal
// multiply that divides local time by one day, the day start and fired
// check, and the deadline decision held in the output register. A new request
// can be taken in every cycle while the receiver keeps rsp_tready high, so the
// sustained rate is then one rule per cycle; the pair of multiplies in the day
// number path sets the stage count.
// Each stage moves forward when it is empty or the stage after it moves,
// so bubbles close up. When the receiver holds rsp_tready low, the output
// register keeps its result, up to three more rules fill the earlier
// stages, and then req_tready drops; nothing is lost or repeated.
// A synchronous reset clears all stage valid bits; no result is pending
// afterwards and the block is ready in the next cycle.
// ----------------------------------------------------------------------------
module daily_alarm_rule_evaluator (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // Fields from bit 0 up: func[1:0].
   input  wire  [7:0]   req_tuser,
   // Fields from bit 0 up: utc_seconds[31:0], due_mark[63:32],
   // minute_of_day[74:64], offset_seconds[91:75], last_mark[123:92],
   // queue_accepts[124], zero fill [127:125].
   input  wire  [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // Fields from bit 0 up: never[0], next_deadline[49:1], post_attempt[50],
   // posted[51], blocked[52], new_last_mark[84:53], zero fill [87:85].
   output logic [87:0]  rsp_tdata
);
   import darule_pkg::*;

   req_type req_data;
   s1_type  s1_data;
   s3_type  s3_data;
   rsp_type rsp_data;
   logic    s1_valid;
   logic    s1_ready;
   logic    s3_valid;
   logic    s3_ready;

   // Unpack the request transfer into its named fields.
   always_comb begin
      req_data.func           = func_type'(req_tuser[1:0]);
      req_data.utc_seconds    = req_tdata[31:0];
      req_data.due_mark       = req_tdata[63:32];
      req_data.minute_of_day  = req_tdata[74:64];
      req_data.offset_seconds = $signed(req_tdata[91:75]);
      req_data.last_mark      = req_tdata[123:92];
      req_data.queue_accepts  = req_tdata[124];
   end

   // Stage one: settings checks, one-shot decision, local time and shifts.
   darule_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   // Stages two and three: local day number, day start and fired check.
   darule_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   // Stage four: deadline choice and post outcome into the output register.
   darule_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   // Pack the result fields, lowest field first, zero filled to bytes.
   assign rsp_tdata = {3'b000,
                       rsp_data.new_last_mark,
                       rsp_data.blocked,
                       rsp_data.posted,
                       rsp_data.post_attempt,
                       rsp_data.next_deadline,
                       rsp_data.never};

`ifndef SYNTHESIS
   // A post is attempted exactly when it either succeeded or was blocked.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_data.post_attempt == (rsp_data.posted || rsp_data.blocked))
                     && !(rsp_data.posted && rsp_data.blocked))
      else $error("post outcome flags disagree");

   // A never result carries no deadline.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data.never) |-> (rsp_data.next_deadline == 49'd0))
      else $error("never result with a deadline");

   // An accepted request always lands in the decode stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid)
      else $error("request transfer lost at decode stage");

   // The mark only changes on a successful post.
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid && s3_ready) |=>
         (rsp_data.posted || rsp_data.new_last_mark == $past(s3_data.com.last)))
      else $error("fired mark changed without a post");
`endif

endmodule
`default_nettype wire

### dv/darule_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// darule_checker: result checker for the alarm rule evaluator
// Watches both stream channels and works out the expected verdict of every
// accepted rule. It then compares each returned result with the oldest
// outstanding verdict, field by field.
// ----------------------------------------------------------------------------
module darule_checker (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire  [7:0]   req_tuser,
   input  wire  [127:0] req_tdata,
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [87:0]  rsp_tdata,
   output int           fault_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import darule_pkg::*;

   localparam longint SECONDS_PER_DAY = 86400;
   localparam longint MINUTES_PER_DAY = 1440;
   localparam longint FIRE_WINDOW     = 60;
   localparam longint TZ_LIMIT        = 50400;
   localparam longint DEADLINE_MASK   = 64'h1_FFFF_FFFF_FFFF;

   rsp_type pending_verdicts[$];
   int      faults = 0;

   // Works out what the evaluator must return for one rule.
   function automatic rsp_type eval_rule(req_type r);
      rsp_type v;
      longint  utc;
      longint  due;
      longint  last;
      longint  offs;
      longint  minute;
      longint  local_sec;
      longint  day;
      longint  shift;
      longint  target;
      longint  next;
      v = '0;
      v.never = 1'b1;
      v.new_last_mark = r.last_mark;
      utc = longint'(r.utc_seconds);
      due = longint'(r.due_mark);
      last = longint'(r.last_mark);
      minute = longint'(r.minute_of_day);
      offs = longint'($signed(r.offset_seconds));
      next = 0;
      if (utc != 0 && r.func == FUNC_ONESHOT) begin
         if (due != 0 && last != due) begin
            if (utc < due) begin
               v.never = 1'b0;
               next = due;
            end else begin
               v.post_attempt = 1'b1;
               if (r.queue_accepts) begin
                  v.posted = 1'b1;
                  v.new_last_mark = r.due_mark;
               end else begin
                  v.blocked = 1'b1;
               end
            end
         end
      end else if (utc != 0 && r.func == FUNC_DAILY) begin
         local_sec = utc + offs;
         if (minute < MINUTES_PER_DAY && offs >= -TZ_LIMIT && offs <= TZ_LIMIT
             && local_sec >= 0) begin
            day = local_sec / SECONDS_PER_DAY;
            shift = minute * FIRE_WINDOW - offs;
            target = day * SECONDS_PER_DAY + shift;
            v.never = 1'b0;
            if (last >= day) begin
               // Already fired in this local day: aim at the day after the mark.
               next = (last + 1) * SECONDS_PER_DAY + shift;
            end else if (utc < target) begin
               next = target;
            end else if (utc >= target + FIRE_WINDOW) begin
               next = target + SECONDS_PER_DAY;
            end else begin
               v.post_attempt = 1'b1;
               if (r.queue_accepts) begin
                  v.posted = 1'b1;
                  v.new_last_mark = day[31:0];
                  next = (day + 1) * SECONDS_PER_DAY + shift;
               end else begin
                  // A refused post is retried until the minute runs out.
                  v.blocked = 1'b1;
                  next = target + FIRE_WINDOW;
               end
            end
         end
      end
      v.next_deadline = v.never ? 49'd0 : 49'(next & DEADLINE_MASK);
      return v;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin
      req_type r;
      rsp_type want;
      rsp_type got;
      if (reset) begin
         pending_verdicts.delete();
      end else begin
         // Retire before queueing, so a result never meets its own request.
         if (rsp_tvalid && rsp_tready) begin
            got.never = rsp_tdata[0];
            got.next_deadline = rsp_tdata[49:1];
            got.post_attempt = rsp_tdata[50];
            got.posted = rsp_tdata[51];
            got.blocked = rsp_tdata[52];
            got.new_last_mark = rsp_tdata[84:53];
            if (pending_verdicts.size() == 0) begin
               $error("result transfer with no outstanding rule");
               faults++;
            end else begin
               want = pending_verdicts.pop_front();
               check_field("never", 64'(want.never), 64'(got.never));
               check_field("next_deadline", 64'(want.next_deadline),
                           64'(got.next_deadline));
               check_field("post_attempt", 64'(want.post_attempt),
                           64'(got.post_attempt));
               check_field("posted", 64'(want.posted), 64'(got.posted));
               check_field("blocked", 64'(want.blocked), 64'(got.blocked));
               check_field("new_last_mark", 64'(want.new_last_mark),
                           64'(got.new_last_mark));
            end
         end
         if (req_tvalid && req_tready) begin
            r.func = func_type'(req_tuser[1:0]);
            r.utc_seconds = req_tdata[31:0];
            r.due_mark = req_tdata[63:32];
            r.minute_of_day = req_tdata[74:64];
            r.offset_seconds = req_tdata[91:75];
            r.last_mark = req_tdata[123:92];
            r.queue_accepts = req_tdata[124];
            pending_verdicts.push_back(eval_rule(r));
         end
      end
      pending_count <= pending_verdicts.size();
      fault_count <= faults;
   end

endmodule
`default_nettype wire

### dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: regression bench for the daily alarm rule evaluator
// Sends a directed set of rules, then three random phases with different
// amounts of sender and receiver idling, and leaves all checking to the
// checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import darule_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_RULES  = 600;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 12;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // Fields from bit 0 up: func[1:0].
   logic [7:0]   req_tuser;
   // Fields from bit 0 up: utc_seconds, due_mark, minute_of_day,
   // offset_seconds, last_mark, queue_accepts, zero fill.
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // Fields from bit 0 up: never, next_deadline, post_attempt, posted,
   // blocked, new_last_mark, zero fill.
   logic [87:0]  rsp_tdata;

   int fault_count;
   int pending_count;
   int cycle_count = 0;

   // Percent chances of a sender gap before each rule and of a receiver stall per cycle.
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit hold_request = 0;

   daily_alarm_rule_evaluator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   darule_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // A hung block must not hang the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver. It stalls at random at the current rate, and when asked it
   // holds tready low for a long stretch so that the pipeline fills up and
   // the block has to drop req_tready.
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
            @(negedge clock);
         end
      end
   end

   // Drives one rule as a transfer. It is called at a falling edge and
   // returns at the falling edge after the transfer, with tvalid still
   // high so that back-to-back rules keep the channel busy.
   task automatic send_rule(req_type r);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tuser <= {6'd0, r.func};
      req_tdata <= {3'd0, r.queue_accepts, r.last_mark, r.offset_seconds,
                    r.minute_of_day, r.due_mark, r.utc_seconds};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Sender pause: lets every outstanding result come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Builds a daily rule whose UTC second lands delta seconds after the
   // firing minute of the given local day.
   function automatic req_type make_daily(longint day, logic [10:0] minute,
                                          longint offs, longint delta,
                                          logic [31:0] last, bit acc);
      req_type r;
      longint  utc;
      utc = day * 86400 + longint'(minute) * 60 - offs + delta;
      if (utc < 1 || utc > 64'hFFFF_FFFF) utc = longint'($urandom_range(1, 32'hFFFF_FFFF));
      r.func = FUNC_DAILY;
      r.utc_seconds = utc[31:0];
      r.due_mark = $urandom;
      r.minute_of_day = minute;
      r.offset_seconds = offs[16:0];
      r.last_mark = last;
      r.queue_accepts = acc;
      return r;
   endfunction

   function automatic req_type make_oneshot(logic [31:0] utc, logic [31:0] due,
                                            logic [31:0] last, bit acc);
      req_type r;
      r.func = FUNC_ONESHOT;
      r.utc_seconds = utc;
      r.due_mark = due;
      r.minute_of_day = 11'($urandom_range(2047));
      r.offset_seconds = 17'($urandom);
      r.last_mark = last;
      r.queue_accepts = acc;
      return r;
   endfunction

   // Random rules. Half are daily rules placed around their firing minute,
   // three tenths are one-shot rules placed around their due second, and the rest
   // is noise over the whole width of every field.
   task automatic run_random_rules(int count);
      req_type     r;
      longint      day;
      longint      offs;
      longint      delta;
      logic [10:0] minute;
      logic [31:0] due;
      logic [31:0] last;
      int          pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            day = longint'($urandom_range(1, 49000));
            minute = 11'($urandom_range(1439));
            offs = longint'($urandom_range(100800)) - 50400;
            case ($urandom_range(5))
               0, 1: delta = longint'($urandom_range(59));
               2: delta = -longint'($urandom_range(1, 4000));
               3: delta = 60 + longint'($urandom_range(4000));
               4: begin
                  case ($urandom_range(3))
                     0: delta = -1;
                     1: delta = 0;
                     2: delta = 59;
                     default: delta = 60;
                  endcase
               end
               default: delta = longint'($urandom_range(172800)) - 86400;
            endcase
            case ($urandom_range(4))
               0: last = 32'(day - 1);
               1: last = 32'(day);
               2: last = $urandom;
               3: last = 32'(day - longint'($urandom_range(2, 500)));
               default: last = 32'(day + 1);
            endcase
            // A few daily rules carry settings the block must refuse.
            case ($urandom_range(32))
               0: minute = 11'($urandom_range(1440, 2047));
               1: offs = 50401 + longint'($urandom_range(15134));
               2: offs = -50401 - longint'($urandom_range(15135));
               default: ;
            endcase
            r = make_daily(day, minute, offs, delta, last, 1'($urandom_range(1)));
         end else if (pick < 80) begin
            due = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
            case ($urandom_range(3))
               0: r = make_oneshot(due - $urandom_range(1, 1000), due, 32'd0, 1'b0);
               1: r = make_oneshot(due, due, 32'd0, 1'b0);
               2: r = make_oneshot(due + $urandom_range(1, 1000), due, 32'd0, 1'b0);
               default: r = make_oneshot($urandom, due, 32'd0, 1'b0);
            endcase
            r.last_mark = ($urandom_range(3) == 0) ? due : $urandom;
            r.queue_accepts = 1'($urandom_range(1));
         end else begin
            r.func = func_type'(2'($urandom_range(3)));
            r.utc_seconds = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
            r.due_mark = $urandom;
            r.minute_of_day = 11'($urandom_range(2047));
            r.offset_seconds = 17'($urandom);
            r.last_mark = $urandom;
            r.queue_accepts = 1'($urandom_range(1));
         end
         send_rule(r);
      end
   endtask

   initial begin
      req_type r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rules: daily firing-minute cases first.
      send_rule(make_daily(19000, 480, 3600, 10, 18999, 1));
      send_rule(make_daily(19000, 480, 3600, 10, 18999, 0));
      send_rule(make_daily(19000, 480, 3600, -30, 18999, 1));
      send_rule(make_daily(19000, 480, 3600, 60, 18999, 1));
      send_rule(make_daily(19000, 480, 3600, 59, 18999, 0));
      send_rule(make_daily(19000, 480, 3600, 10, 19000, 1));
      send_rule(make_daily(19000, 480, 3600, 10, 32'hFFFF_FFFF, 1));
      send_rule(make_daily(49000, 1439, 50400, 59, 0, 1));
      send_rule(make_daily(1, 0, -50400, 0, 0, 1));
      send_rule(make_daily(0, 1, 0, 5, 0, 1));
      // Daily settings out of range, and local time before the epoch.
      send_rule(make_daily(19000, 1440, 0, 0, 0, 1));
      send_rule(make_daily(19000, 2047, 0, 0, 0, 1));
      send_rule(make_daily(19000, 600, 50401, 0, 0, 1));
      send_rule(make_daily(19000, 600, -50401, 0, 0, 1));
      send_rule(make_daily(19000, 600, -65536, 0, 0, 1));
      send_rule(make_daily(19000, 600, 65535, 0, 0, 1));
      r = make_daily(0, 0, 0, 100, 0, 1);
      r.offset_seconds = -17'sd50400;
      send_rule(r);
      // Unknown time, and the disabled and unused kinds.
      r = make_daily(19000, 480, 3600, 10, 18999, 1);
      r.utc_seconds = '0;
      send_rule(r);
      r.func = FUNC_DISABLED;
      r.utc_seconds = 32'd1641600000;
      send_rule(r);
      r.func = FUNC_UNUSED;
      send_rule(r);
      // One-shot rules: unset, already fired, unknown time, early, due.
      send_rule(make_oneshot(32'd5000, 32'd0, 32'd0, 1));
      send_rule(make_oneshot(32'd5000, 32'd4000, 32'd4000, 1));
      send_rule(make_oneshot(32'd0, 32'd4000, 32'd0, 1));
      send_rule(make_oneshot(32'd3999, 32'd4000, 32'd0, 1));
      send_rule(make_oneshot(32'd4000, 32'd4000, 32'd0, 1));
      send_rule(make_oneshot(32'd4500, 32'd4000, 32'd0, 0));
      send_rule(make_oneshot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1));
      drain_results();

      // Phase one: light sender gaps, a receiver that stalls most cycles,
      // and one long hold-off while the sender keeps offering rules.
      tx_idle_pct = 12;
      rx_stall_pct = 63;
      hold_request = 1;
      run_random_rules(PHASE_RULES);
      drain_results();

      // Phase two: the other way round.
      tx_idle_pct = 63;
      rx_stall_pct = 12;
      run_random_rules(PHASE_RULES);
      drain_results();

      // Phase three: full rate on both sides, with a second hold-off.
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_request = 1;
      run_random_rules(PHASE_RULES);
      drain_results();

      // Extra cycles so that a stray result after the last one is caught.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire

### files.f
rtl/darule_pkg.sv
rtl/darule_front.sv
rtl/darule_divide.sv
rtl/darule_resolve.sv
rtl/daily_alarm_rule_evaluator.sv
dv/darule_checker.sv
dv/tb.sv
